>>> src/ayp_pkg.sv
package ayp_pkg;

    // Coordinate and datapath widths.
    localparam int COORD_WIDTH   = 32;
    localparam int CORDIC_STAGES = 16;
    localparam int ANG_TABLE_LEN = 24;
    localparam int CORDIC_RUN    = (CORDIC_STAGES < ANG_TABLE_LEN) ? CORDIC_STAGES
                                                                   : ANG_TABLE_LEN;
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int MAG_W   = COORD_WIDTH + 1;
    localparam int SHIFT_W = 6;
    localparam int CX_W    = 44;
    localparam int ANG_W   = 24;

    // Pitch path: scaled components stay below 2^30.
    localparam int PSC_W   = 30;
    localparam int SQ_W    = 2 * PSC_W;
    localparam int REM_W   = SQ_W + 2;
    localparam int ROOT_W  = REM_W + 1;
    localparam int LEN_W   = REM_W / 2;
    localparam int SQRT_STEPS   = REM_W / 2 + 1;
    localparam int SQRT_PER_STG = 2;
    localparam int SQRT_STG     = (SQRT_STEPS + SQRT_PER_STG - 1) / SQRT_PER_STG;
    localparam int ITER_STG     = (SQRT_STG > CORDIC_RUN) ? SQRT_STG : CORDIC_RUN;

    // Pitch division: quotient bits and numerator width.
    localparam int DIV_BITS    = 16;
    localparam int DIV_PER_STG = 2;
    localparam int DIV_STG     = DIV_BITS / DIV_PER_STG;
    localparam int DEN_W       = LEN_W + 1;
    localparam int NUM_W       = PSC_W + 17;
    localparam int CMP_W       = NUM_W + 1;

    // Total stages behind the front end (iterations, divider setup, divider).
    localparam int MID_STG = ITER_STG + 1 + DIV_STG;

    // Yaw normalization target and output limits.
    localparam int YAW_MSB   = 39;
    localparam int PITCH_ONE = 16384;
    localparam int YAW_LIMIT = 25736;

    typedef struct packed {
        logic               target_present;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] self_x;
        logic signed [31:0] self_y;
        logic signed [31:0] self_z;
    } in_t;

    typedef struct packed {
        logic signed [15:0] pitch_term;
        logic signed [15:0] yaw_angle;
    } out_t;

    // Everything one item carries down the pipeline.
    typedef struct packed {
        logic                     live;
        logic                     yaw_zero;
        logic                     dy_pos;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] dz;
        logic [MAG_W-1:0]         ax;
        logic [MAG_W-1:0]         ay;
        logic [MAG_W-1:0]         az;
        logic [MAG_W-1:0]         mp;
        logic [MAG_W-1:0]         my;
        logic [PSC_W-1:0]         px;
        logic [PSC_W-1:0]         py;
        logic [PSC_W-1:0]         pz;
        logic [SQ_W-1:0]          qx;
        logic [SQ_W-1:0]          qy;
        logic [SQ_W-1:0]          qz;
        logic [REM_W-1:0]         rem;
        logic [ROOT_W-1:0]        root;
        logic signed [CX_W-1:0]   cx;
        logic signed [CX_W-1:0]   cy;
        logic signed [ANG_W-1:0]  ang;
        logic [NUM_W-1:0]         num;
        logic [DEN_W-1:0]         den;
        logic [DIV_BITS-1:0]      quo;
    } pipe_t;

    // atan(2^-i) in Q.20.
    function automatic logic signed [ANG_W-1:0] ang_tab(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:       v = 24'sd823550;
            1:       v = 24'sd486170;
            2:       v = 24'sd256879;
            3:       v = 24'sd130396;
            4:       v = 24'sd65451;
            5:       v = 24'sd32757;
            6:       v = 24'sd16383;
            7:       v = 24'sd8192;
            8:       v = 24'sd4096;
            9:       v = 24'sd2048;
            10:      v = 24'sd1024;
            11:      v = 24'sd512;
            12:      v = 24'sd256;
            13:      v = 24'sd128;
            14:      v = 24'sd64;
            15:      v = 24'sd32;
            16:      v = 24'sd16;
            17:      v = 24'sd8;
            18:      v = 24'sd4;
            19:      v = 24'sd2;
            20:      v = 24'sd1;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

    // Sign-extend the low COORD_WIDTH bits of a coordinate.
    function automatic logic signed [DIFF_W-1:0] coord_sext(input logic [31:0] v);
        return DIFF_W'($signed(v[COORD_WIDTH-1:0]));
    endfunction

    // Index of the highest set bit (zero for a zero word).
    function automatic logic [SHIFT_W-1:0] msb_pos(input logic [MAG_W-1:0] v);
        logic [SHIFT_W-1:0] p;
        p = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (v[i]) begin
                p = SHIFT_W'(i);
            end
        end
        return p;
    endfunction

    // Two square-root digits and one vectoring rotation.
    function automatic pipe_t iter_step(input pipe_t p, input int k);
        pipe_t             r;
        logic [ROOT_W-1:0] bitv;
        logic [ROOT_W-1:0] trial;
        int                s;
        r = p;
        for (int t = 0; t < SQRT_PER_STG; t++) begin
            s = k * SQRT_PER_STG + t;
            if (s < SQRT_STEPS) begin
                bitv  = ROOT_W'(1) << (REM_W - 2 * s);
                trial = r.root + bitv;
                if ({1'b0, r.rem} >= trial) begin
                    r.rem  = REM_W'({1'b0, r.rem} - trial);
                    r.root = (r.root >> 1) + bitv;
                end else begin
                    r.root = r.root >> 1;
                end
            end
        end
        if (k < CORDIC_RUN) begin
            if (!p.cy[CX_W-1]) begin
                r.cx  = p.cx + (p.cy >>> k);
                r.cy  = p.cy - (p.cx >>> k);
                r.ang = p.ang + ang_tab(k);
            end else begin
                r.cx  = p.cx - (p.cy >>> k);
                r.cy  = p.cy + (p.cx >>> k);
                r.ang = p.ang - ang_tab(k);
            end
        end
        return r;
    endfunction

    // Numerator and divisor of the rounded pitch quotient.
    function automatic pipe_t div_prep(input pipe_t p);
        pipe_t r;
        r     = p;
        r.den = {p.root[LEN_W-1:0], 1'b0};
        r.num = NUM_W'({p.py, 15'b0}) + NUM_W'(p.root[LEN_W-1:0]);
        r.quo = '0;
        return r;
    endfunction

    // Two restoring division steps.
    function automatic pipe_t div_step(input pipe_t p, input int k);
        pipe_t            r;
        logic [CMP_W-1:0] dsh;
        int               b;
        r = p;
        for (int t = 0; t < DIV_PER_STG; t++) begin
            b   = DIV_BITS - 1 - (k * DIV_PER_STG + t);
            dsh = CMP_W'(r.den) << b;
            if ({1'b0, r.num} >= dsh) begin
                r.num    = NUM_W'({1'b0, r.num} - dsh);
                r.quo[b] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

>>> src/ayp_front.sv
module ayp_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          s_valid,
    input  ayp_pkg::in_t  s_data,
    output logic          f_valid,
    output ayp_pkg::pipe_t f_pipe
);
    import ayp_pkg::*;

    pipe_t            a_reg, a_next, b_reg, b_next, c_reg, c_next;
    pipe_t            d_reg, d_next, e_reg, e_next;
    logic [4:0]       vld_reg;
    logic [SHIFT_W-1:0] mp_msb, my_msb;

    // Differences of the two positions.
    always_comb begin
        a_next      = '0;
        a_next.live = s_data.target_present;
        a_next.dx   = coord_sext(s_data.target_x) - coord_sext(s_data.self_x);
        a_next.dy   = coord_sext(s_data.target_y) - coord_sext(s_data.self_y);
        a_next.dz   = coord_sext(s_data.target_z) - coord_sext(s_data.self_z);
    end

    // Magnitudes, zero tests and the largest magnitudes.
    always_comb begin
        b_next          = a_reg;
        b_next.live     = a_reg.live && (a_reg.dx != '0 || a_reg.dy != '0 || a_reg.dz != '0);
        b_next.yaw_zero = (a_reg.dx == '0) && (a_reg.dz == '0);
        b_next.dy_pos   = !a_reg.dy[DIFF_W-1] && (a_reg.dy != '0);
        b_next.ax       = MAG_W'(a_reg.dx[DIFF_W-1] ? -a_reg.dx : a_reg.dx);
        b_next.ay       = MAG_W'(a_reg.dy[DIFF_W-1] ? -a_reg.dy : a_reg.dy);
        b_next.az       = MAG_W'(a_reg.dz[DIFF_W-1] ? -a_reg.dz : a_reg.dz);
        b_next.my       = (b_next.ax > b_next.az) ? b_next.ax : b_next.az;
        b_next.mp       = (b_next.ay > b_next.my) ? b_next.ay : b_next.my;
    end

    // Common scaling: below 2^30 for the pitch, top bit at 2^39 for the yaw.
    always_comb begin
        mp_msb = msb_pos(b_reg.mp);
        my_msb = msb_pos(b_reg.my);
        c_next = b_reg;
        if (mp_msb >= SHIFT_W'(PSC_W)) begin
            c_next.px = PSC_W'(b_reg.ax >> (mp_msb - SHIFT_W'(PSC_W - 1)));
            c_next.py = PSC_W'(b_reg.ay >> (mp_msb - SHIFT_W'(PSC_W - 1)));
            c_next.pz = PSC_W'(b_reg.az >> (mp_msb - SHIFT_W'(PSC_W - 1)));
        end else begin
            c_next.px = PSC_W'(b_reg.ax);
            c_next.py = PSC_W'(b_reg.ay);
            c_next.pz = PSC_W'(b_reg.az);
        end
        c_next.cx = $signed(CX_W'(b_reg.az) << (SHIFT_W'(YAW_MSB) - my_msb));
        c_next.cy = $signed(CX_W'(b_reg.ax) << (SHIFT_W'(YAW_MSB) - my_msb));
    end

    // Squares for the length; signs restored on the yaw vector.
    always_comb begin
        d_next    = c_reg;
        d_next.qx = c_reg.px * c_reg.px;
        d_next.qy = c_reg.py * c_reg.py;
        d_next.qz = c_reg.pz * c_reg.pz;
        d_next.cx = c_reg.dz[DIFF_W-1] ? -c_reg.cx : c_reg.cx;
        d_next.cy = c_reg.dx[DIFF_W-1] ? -c_reg.cy : c_reg.cy;
    end

    // Sum of squares, and a quarter turn when the vector points backward.
    always_comb begin
        e_next      = d_reg;
        e_next.rem  = REM_W'(d_reg.qx) + REM_W'(d_reg.qy) + REM_W'(d_reg.qz);
        e_next.root = '0;
        e_next.ang  = '0;
        if (d_reg.cx[CX_W-1]) begin
            if (!d_reg.cy[CX_W-1]) begin
                e_next.cx  = d_reg.cy;
                e_next.cy  = -d_reg.cx;
                e_next.ang = ang_tab(0) <<< 1;
            end else begin
                e_next.cx  = -d_reg.cy;
                e_next.cy  = d_reg.cx;
                e_next.ang = -(ang_tab(0) <<< 1);
            end
        end
    end

    // Stage registers move together when the pipeline is enabled.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
            e_reg <= e_next;
        end
    end

    assign f_valid = vld_reg[4];
    assign f_pipe  = e_reg;

endmodule

>>> src/aim_direction_yaw_pitch.sv
// Aim direction unit: pitch term and yaw angle from an observer and a target.
//
// Input channel s_*: one beat carries the target-present flag and both
// positions as signed Q16.16. Result channel m_*: one beat per input beat,
// pitch_term (-dy/|d|, Q1.14) and yaw_angle (atan2(dx, dz), Q2.13), in order.
// An absent target or coincident positions give zero on both fields.
//
// Throughput is one beat per cycle while no result is stalled. From an
// accepted input beat to m_valid an item passes 5 front-end stages
// (difference, magnitude, scaling, squares, sum), 16 stages that each run two
// square-root digits and one CORDIC rotation, one divider setup stage, 8
// divider stages of two quotient bits each, and the output register.
//
// All stages share one enable: when m_valid is high and m_ready is low the
// whole pipeline holds and s_ready drops in the same cycle, so nothing is
// lost or repeated. Reset (aresetn low, synchronous) clears every valid bit;
// no results are pending afterward and s_ready is high.
module aim_direction_yaw_pitch (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ayp_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output ayp_pkg::out_t m_data
);
    import ayp_pkg::*;

    logic                      en;
    logic                      f_valid;
    pipe_t                     f_pipe;
    pipe_t                     stage_reg [MID_STG];
    logic [MID_STG-1:0]        vld_reg;
    logic                      m_valid_reg;
    out_t                      out_reg, out_next;
    pipe_t                     last;
    logic [DIV_BITS-1:0]       qc;
    logic signed [ANG_W-1:0]   ang_rnd;

    // One enable for every stage.
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    ayp_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .s_valid (s_valid),
        .s_data  (s_data),
        .f_valid (f_valid),
        .f_pipe  (f_pipe)
    );

    // Iteration stages, divider setup and divider stages.
    for (genvar k = 0; k < MID_STG; k++) begin : g_stage
        pipe_t stg_in, stg_next;
        logic  vld_in;
        if (k == 0) begin : g_first
            assign stg_in = f_pipe;
            assign vld_in = f_valid;
        end else begin : g_rest
            assign stg_in = stage_reg[k-1];
            assign vld_in = vld_reg[k-1];
        end
        if (k < ITER_STG) begin : g_iter
            assign stg_next = iter_step(stg_in, k);
        end else if (k == ITER_STG) begin : g_prep
            assign stg_next = div_prep(stg_in);
        end else begin : g_div
            assign stg_next = div_step(stg_in, k - ITER_STG - 1);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                stage_reg[k] <= stg_next;
            end
        end
    end

    // Final sign, rounding and clamping.
    always_comb begin
        last     = stage_reg[MID_STG-1];
        qc       = (last.quo > DIV_BITS'(PITCH_ONE)) ? DIV_BITS'(PITCH_ONE) : last.quo;
        ang_rnd  = (last.ang + ANG_W'(64)) >>> 7;
        out_next = '0;
        if (last.live && last.den != '0) begin
            out_next.pitch_term = last.dy_pos ? -$signed(qc) : $signed(qc);
        end
        if (last.live && !last.yaw_zero) begin
            if (ang_rnd > ANG_W'(YAW_LIMIT)) begin
                out_next.yaw_angle = 16'(YAW_LIMIT);
            end else if (ang_rnd < -ANG_W'(YAW_LIMIT)) begin
                out_next.yaw_angle = -16'(YAW_LIMIT);
            end else begin
                out_next.yaw_angle = 16'(ang_rnd);
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld_reg[MID_STG-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> src/ayp_checker.sv
module ayp_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input ayp_pkg::in_t  s_data,
    input logic          m_valid,
    input logic          m_ready,
    input ayp_pkg::out_t m_data
);
    import ayp_pkg::*;

    // No result beat is offered right after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat offered after reset");

    // A waiting input beat holds until it is taken.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("waiting input beat changed");

    // A stalled result beat holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

    // The input side only stalls while a result is blocked.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow the output stall");

    // Result fields stay within their ranges.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.pitch_term <= 16'sd16384) && (m_data.pitch_term >= -16'sd16384)
                 && (m_data.yaw_angle <= 16'sd25736) && (m_data.yaw_angle >= -16'sd25736))
        else $error("result field out of range");

endmodule

bind aim_direction_yaw_pitch ayp_checker u_ayp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ayp_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int RANDOM_ITEMS   = 1880;
    localparam longint ATAN_Q20 [24] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0, 0, 0
    };

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    in_t  query_queue [$];
    out_t aim_expected [$];
    int   send_idle_pct;
    int   recv_stall_pct;
    int   errors;
    int   quiet_cycles;

    aim_direction_yaw_pitch dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Free-running clock.
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Integer square root, rounded down.
    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) begin
            bitv = bitv >> 2;
        end
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Pitch term: -dy / |d| rounded to Q1.14.
    function automatic longint pitch_of(input longint dx, input longint dy, input longint dz);
        longint unsigned ax, ay, az, m, len, q;
        ax = magnitude(dx);
        ay = magnitude(dy);
        az = magnitude(dz);
        m  = ax;
        if (ay > m) begin
            m = ay;
        end
        if (az > m) begin
            m = az;
        end
        while (m >= (64'd1 << 30)) begin
            m  = m >> 1;
            ax = ax >> 1;
            ay = ay >> 1;
            az = az >> 1;
        end
        len = root_floor(ax * ax + ay * ay + az * az);
        if (len == 0) begin
            return 0;
        end
        q = (2 * ay * 16384 + len) / (2 * len);
        if (q > 16384) begin
            q = 16384;
        end
        return (dy > 0) ? -longint'(q) : longint'(q);
    endfunction

    // Yaw angle: vectoring rotation of (dz, dx), accumulated in Q.20, rounded to Q2.13.
    function automatic longint yaw_of(input longint dx, input longint dz);
        longint unsigned ax, az, m;
        longint xv, yv, xn, yn, acc;
        ax  = magnitude(dx);
        az  = magnitude(dz);
        acc = 0;
        m   = (ax > az) ? ax : az;
        if (m == 0) begin
            return 0;
        end
        while (m >= (64'd1 << 40)) begin
            m  = m >> 1;
            ax = ax >> 1;
            az = az >> 1;
        end
        while (m < (64'd1 << 39)) begin
            m  = m << 1;
            ax = ax << 1;
            az = az << 1;
        end
        xv = (dz < 0) ? -longint'(az) : longint'(az);
        yv = (dx < 0) ? -longint'(ax) : longint'(ax);
        // Left half plane: turn by a quarter first.
        if (xv < 0) begin
            if (yv >= 0) begin
                xn  = yv;
                yn  = -xv;
                acc = 2 * ATAN_Q20[0];
            end else begin
                xn  = -yv;
                yn  = xv;
                acc = -2 * ATAN_Q20[0];
            end
            xv = xn;
            yv = yn;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            if (yv >= 0) begin
                xn  = xv + (yv >>> i);
                yn  = yv - (xv >>> i);
                acc = acc + ATAN_Q20[i];
            end else begin
                xn  = xv - (yv >>> i);
                yn  = yv + (xv >>> i);
                acc = acc - ATAN_Q20[i];
            end
            xv = xn;
            yv = yn;
        end
        acc = (acc + 64) >>> 7;
        if (acc > YAW_LIMIT) begin
            acc = YAW_LIMIT;
        end
        if (acc < -YAW_LIMIT) begin
            acc = -YAW_LIMIT;
        end
        return acc;
    endfunction

    function automatic out_t aim_predict(input in_t q);
        out_t   r;
        longint dx, dy, dz;
        r = '0;
        if (!q.target_present) begin
            return r;
        end
        dx = longint'(q.target_x) - longint'(q.self_x);
        dy = longint'(q.target_y) - longint'(q.self_y);
        dz = longint'(q.target_z) - longint'(q.self_z);
        if (dx == 0 && dy == 0 && dz == 0) begin
            return r;
        end
        r.pitch_term = 16'(pitch_of(dx, dy, dz));
        r.yaw_angle  = 16'(yaw_of(dx, dz));
        return r;
    endfunction

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    // Target near or far from the observer, with absent, coincident and vertical cases.
    function automatic in_t random_query();
        in_t q;
        q.target_present = ($urandom_range(0, 19) != 0);
        q.self_x = random_coord();
        q.self_y = random_coord();
        q.self_z = random_coord();
        if ($urandom_range(0, 1)) begin
            q.target_x = random_coord();
            q.target_y = random_coord();
            q.target_z = random_coord();
        end else begin
            q.target_x = q.self_x + random_coord();
            q.target_y = q.self_y + random_coord();
            q.target_z = q.self_z + random_coord();
        end
        case ($urandom_range(0, 15))
            0: begin
                q.target_x = q.self_x;
                q.target_y = q.self_y;
                q.target_z = q.self_z;
            end
            1: begin
                q.target_x = q.self_x;
                q.target_z = q.self_z;
            end
            2: q.target_x = q.self_x;
            3: q.target_z = q.self_z;
            default: ;
        endcase
        return q;
    endfunction

    function automatic in_t make_query(input logic present,
                                       input logic [31:0] tx, input logic [31:0] ty,
                                       input logic [31:0] tz, input logic [31:0] sx,
                                       input logic [31:0] sy, input logic [31:0] sz);
        in_t q;
        q.target_present = present;
        q.target_x = tx;
        q.target_y = ty;
        q.target_z = tz;
        q.self_x   = sx;
        q.self_y   = sy;
        q.self_z   = sz;
        return q;
    endfunction

    // Driver: present the next query beat, record its expected result on acceptance.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                aim_expected.push_back(aim_predict(s_data));
            end
            if (!s_valid || s_ready) begin
                if (query_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= query_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result beat with the oldest expectation.
    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (aim_expected.size() == 0) begin
                    $error("result beat with no expectation: pitch %0d yaw %0d",
                           m_data.pitch_term, m_data.yaw_angle);
                    errors++;
                end else begin
                    want = aim_expected.pop_front();
                    if (m_data.pitch_term !== want.pitch_term) begin
                        $error("pitch_term expected %0d actual %0d",
                               want.pitch_term, m_data.pitch_term);
                        errors++;
                    end
                    if (m_data.yaw_angle !== want.yaw_angle) begin
                        $error("yaw_angle expected %0d actual %0d",
                               want.yaw_angle, m_data.yaw_angle);
                        errors++;
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;
        aresetn        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        errors         = 0;
        quiet_cycles   = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed cases: absent target, coincident points, vertical, extremes, quadrants.
        query_queue.push_back(make_query(0, 100, 200, 300, 0, 0, 0));
        query_queue.push_back(make_query(1, 5, 6, 7, 5, 6, 7));
        query_queue.push_back(make_query(1, 0, 32'h0001_0000, 0, 0, 0, 0));
        query_queue.push_back(make_query(1, 0, 32'hFFFF_0000, 0, 0, 0, 0));
        query_queue.push_back(make_query(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        query_queue.push_back(make_query(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        query_queue.push_back(make_query(1, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 0, 0));
        query_queue.push_back(make_query(1, 0, 0, 1, 0, 0, 0));
        query_queue.push_back(make_query(1, 0, 0, -1, 0, 0, 0));
        query_queue.push_back(make_query(1, 1, 0, 0, 0, 0, 0));
        query_queue.push_back(make_query(1, -1, 0, 0, 0, 0, 0));
        query_queue.push_back(make_query(1, 1, 0, -1, 0, 0, 0));
        query_queue.push_back(make_query(1, -1, 0, -1, 0, 0, 0));
        query_queue.push_back(make_query(1, 1, 1, 1, 0, 0, 0));
        query_queue.push_back(make_query(1, -3, 4, 0, 0, 0, 0));
        query_queue.push_back(make_query(1, 0, -1, 1, 0, 0, 0));
        query_queue.push_back(make_query(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                         0, 0, 0));
        query_queue.push_back(make_query(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                         32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678));

        // Random queries across four handshake phases.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
                query_queue.push_back(random_query());
            end
            while (query_queue.size() != 0 || s_valid) begin
                @(posedge aclk);
            end
        end

        // Drain outstanding results.
        while (aim_expected.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
